FILE: hw/rtl/spt_pkg.sv
`timescale 1ns / 1ps

package spt_pkg;

   localparam int NumWeightsDefault  = 4096;
   localparam int MaxFeaturesDefault = 64;
   localparam int QueueDepthDefault  = 2;

   localparam int ModeWidth   = 2;
   localparam int IdWidth     = 12;
   localparam int ValueWidth  = 16;
   localparam int WeightWidth = 32;
   localparam int RateWidth   = 24;
   localparam int AccWidth    = 56;
   localparam int ErrWidth    = 32;

   localparam logic [RateWidth-1:0] RateReset = 24'd16777;

   typedef enum logic [ModeWidth-1:0] {
      MODE_FEATURE = 2'd0,
      MODE_END     = 2'd1,
      MODE_READ    = 2'd2,
      MODE_CLEAR   = 2'd3
   } mode_type;

   // one classified request as it sits in the queue
   typedef struct packed {
      mode_type                      mode;
      logic [IdWidth-1:0]            id;
      logic signed [ValueWidth-1:0]  value;
      logic                          label;
      logic                          in_range;
   } op_type;

   // queue and back-end status seen by the front
   typedef struct packed {
      logic full;
      logic busy;
   } front_status_type;

endpackage

FILE: hw/rtl/spt_req_if.sv
`timescale 1ns / 1ps

interface spt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [11:0]        feature_id;
   logic signed [15:0] feature_value;
   logic               label_is_one;

   modport source (output valid, mode, feature_id, feature_value, label_is_one, input ready);
   modport sink (input valid, mode, feature_id, feature_value, label_is_one, output ready);
endinterface

FILE: hw/rtl/spt_rsp_if.sv
`timescale 1ns / 1ps

interface spt_rsp_if;
   logic               valid;
   logic               ready;
   logic               predicted;
   logic               mistake;
   logic [31:0]        error_count;
   logic               overflowed;
   logic signed [31:0] weight_value;

   modport source (output valid, predicted, mistake, error_count, overflowed, weight_value,
                   input ready);
   modport sink (input valid, predicted, mistake, error_count, overflowed, weight_value,
                 output ready);
endinterface

FILE: hw/rtl/spt_front.sv
`timescale 1ns / 1ps

module spt_front #(
   parameter int NUM_WEIGHTS = spt_pkg::NumWeightsDefault
) (
   spt_req_if.sink                   req,
   input  spt_pkg::front_status_type status,
   output logic                      push,
   output spt_pkg::op_type           op
);
   import spt_pkg::*;

   // no transfers while the back end sweeps the weight memory
   assign req.ready = !status.full && !status.busy;
   assign push      = req.valid && req.ready;

   always_comb begin
      op.mode     = mode_type'(req.mode);
      op.id       = req.feature_id;
      op.value    = req.feature_value;
      op.label    = req.label_is_one;
      op.in_range = 32'(req.feature_id) < 32'(NUM_WEIGHTS);
   end

endmodule

FILE: hw/rtl/spt_queue.sv
`timescale 1ns / 1ps

module spt_queue #(
   parameter int DEPTH = spt_pkg::QueueDepthDefault
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  spt_pkg::op_type push_data,
   output logic            full,
   input  logic            pop,
   output spt_pkg::op_type pop_data,
   output logic            empty
);
   import spt_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   op_type          mem [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full     = count_ff == CW'(DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/spt_back.sv
`timescale 1ns / 1ps

module spt_back #(
   parameter int NUM_WEIGHTS  = spt_pkg::NumWeightsDefault,
   parameter int MAX_FEATURES = spt_pkg::MaxFeaturesDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [spt_pkg::RateWidth-1:0]   rate,
   input  logic                            empty,
   input  spt_pkg::op_type                 pop_data,
   output logic                            pop,
   output logic                            busy,
   spt_rsp_if.source                       rsp
);
   import spt_pkg::*;

   localparam int AW  = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
   localparam int BW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int FCW = $clog2(MAX_FEATURES + 1);
   localparam int PW  = WeightWidth + ValueWidth;
   localparam int SW  = RateWidth + ValueWidth + 1;
   localparam int DW  = WeightWidth - 2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_F_MUL,
      ST_F_ACC,
      ST_BIAS,
      ST_U_LOAD,
      ST_U_WR,
      ST_FINISH,
      ST_READ
   } state_type;

   state_type                    state_ff;
   logic [AW-1:0]                clr_ff;
   logic signed [AccWidth-1:0]   acc_ff;
   logic [FCW-1:0]               count_ff;
   logic [FCW-1:0]               k_ff;
   logic [ErrWidth-1:0]          mistakes_ff;
   logic                         ovf_ff;
   logic signed [ValueWidth-1:0] val_ff;
   logic                         inr_ff;
   logic                         sign_ff;
   logic                         pred_ff;
   logic                         miss_ff;
   logic signed [PW-1:0]         prod_ff;
   logic signed [SW-1:0]         step_ff;
   logic [AW-1:0]                uaddr_ff;

   logic                         rsp_valid_ff;
   logic                         rsp_pred_ff;
   logic                         rsp_miss_ff;
   logic [ErrWidth-1:0]          rsp_err_ff;
   logic                         rsp_ovf_ff;
   logic signed [WeightWidth-1:0] rsp_weight_ff;

   // weight memory and feature buffer
   logic signed [WeightWidth-1:0] wmem [NUM_WEIGHTS];
   logic signed [WeightWidth-1:0] w_rd_q;
   logic [IdWidth-1:0]            buf_ids [MAX_FEATURES];
   logic signed [ValueWidth-1:0]  buf_vals [MAX_FEATURES];
   logic [IdWidth-1:0]            buf_id_q;
   logic signed [ValueWidth-1:0]  buf_val_q;

   logic                          w_we;
   logic [AW-1:0]                 w_waddr;
   logic signed [WeightWidth-1:0] w_wdata;
   logic [AW-1:0]                 w_raddr;
   logic                          b_we;
   logic [BW-1:0]                 b_waddr;
   logic [BW-1:0]                 b_raddr;

   logic                          op_needs_rsp;
   logic                          buf_has_room;
   logic                          pred_now;
   logic signed [PW-1:0]          prod_in;
   logic signed [AccWidth:0]      acc_sum;
   logic signed [AccWidth-1:0]    acc_in;
   logic signed [SW-1:0]          step_in;
   logic signed [SW-1:0]          step_rnd;
   logic signed [DW-1:0]          delta_mag;
   logic signed [DW-1:0]          delta;
   logic signed [WeightWidth+1:0] w_sum;
   logic signed [WeightWidth-1:0] w_sat;
   logic                          last_feature;

   function automatic logic [AW-1:0] id_addr(input logic [IdWidth-1:0] id);
      logic [31:0] ext;
      ext = 32'(id);
      return ext[AW-1:0];
   endfunction

   assign busy         = state_ff == ST_CLEAR;
   assign op_needs_rsp = pop_data.mode == MODE_END || pop_data.mode == MODE_READ;
   assign pop          = state_ff == ST_IDLE && !empty && !(op_needs_rsp && rsp_valid_ff);
   assign buf_has_room = count_ff < FCW'(MAX_FEATURES);
   assign pred_now     = acc_ff > 0;
   assign last_feature = (k_ff + 1'b1) == count_ff;

   // dot product term and saturating sum
   assign prod_in = w_rd_q * val_ff;
   assign acc_sum = (AccWidth + 1)'(acc_ff) + (AccWidth + 1)'(prod_ff);
   always_comb begin
      if (acc_sum[AccWidth] != acc_sum[AccWidth-1]) begin
         acc_in = acc_sum[AccWidth] ? {1'b1, {(AccWidth - 1){1'b0}}}
                                    : {1'b0, {(AccWidth - 1){1'b1}}};
      end else begin
         acc_in = acc_sum[AccWidth-1:0];
      end
   end

   // update step: rate * value, round half up to q8.24
   assign step_in   = $signed({1'b0, rate}) * buf_val_q;
   assign step_rnd  = (step_ff + SW'(2048)) >>> 12;
   assign delta_mag = (state_ff == ST_BIAS) ? DW'($signed({1'b0, rate})) : DW'(step_rnd);
   assign delta     = sign_ff ? delta_mag : -delta_mag;
   assign w_sum     = (WeightWidth + 2)'(w_rd_q) + (WeightWidth + 2)'(delta);
   always_comb begin
      if (w_sum[WeightWidth+1:WeightWidth-1] == 3'b000 ||
          w_sum[WeightWidth+1:WeightWidth-1] == 3'b111) begin
         w_sat = w_sum[WeightWidth-1:0];
      end else if (w_sum[WeightWidth+1]) begin
         w_sat = {1'b1, {(WeightWidth - 1){1'b0}}};
      end else begin
         w_sat = {1'b0, {(WeightWidth - 1){1'b1}}};
      end
   end

   // memory port control
   always_comb begin
      w_we    = 1'b0;
      w_waddr = '0;
      w_wdata = w_sat;
      w_raddr = '0;
      b_we    = 1'b0;
      b_waddr = count_ff[BW-1:0];
      b_raddr = '0;
      case (state_ff)
         ST_CLEAR: begin
            w_we    = 1'b1;
            w_waddr = clr_ff;
            w_wdata = '0;
         end
         ST_IDLE: begin
            // an end item fetches the bias weight for a possible update
            w_raddr = (pop_data.mode == MODE_END) ? '0 : id_addr(pop_data.id);
            if (pop && pop_data.mode == MODE_FEATURE && buf_has_room) begin
               b_we = 1'b1;
            end
         end
         ST_BIAS: begin
            w_we = 1'b1;
         end
         ST_U_LOAD: begin
            w_raddr = id_addr(buf_id_q);
         end
         ST_U_WR: begin
            w_we    = inr_ff;
            w_waddr = uaddr_ff;
            b_raddr = BW'(k_ff + 1'b1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         wmem[w_waddr] <= w_wdata;
      end
      w_rd_q <= wmem[w_raddr];
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         buf_ids[b_waddr]  <= pop_data.id;
         buf_vals[b_waddr] <= pop_data.value;
      end
      buf_id_q  <= buf_ids[b_raddr];
      buf_val_q <= buf_vals[b_raddr];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         acc_ff       <= '0;
         count_ff     <= '0;
         k_ff         <= '0;
         mistakes_ff  <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AW'(NUM_WEIGHTS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (pop) begin
                  val_ff <= pop_data.value;
                  inr_ff <= pop_data.in_range;
                  case (pop_data.mode)
                     MODE_FEATURE: begin
                        if (buf_has_room) begin
                           count_ff <= count_ff + 1'b1;
                           state_ff <= ST_F_MUL;
                        end else begin
                           ovf_ff <= 1'b1;
                        end
                     end
                     MODE_END: begin
                        pred_ff <= pred_now;
                        miss_ff <= pred_now != pop_data.label;
                        sign_ff <= pop_data.label;
                        if (pred_now != pop_data.label) begin
                           if (mistakes_ff != '1) begin
                              mistakes_ff <= mistakes_ff + 1'b1;
                           end
                           state_ff <= ST_BIAS;
                        end else begin
                           state_ff <= ST_FINISH;
                        end
                     end
                     MODE_READ: begin
                        state_ff <= ST_READ;
                     end
                     MODE_CLEAR: begin
                        mistakes_ff <= '0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_F_MUL: begin
               prod_ff  <= inr_ff ? prod_in : '0;
               state_ff <= ST_F_ACC;
            end
            ST_F_ACC: begin
               acc_ff   <= acc_in;
               state_ff <= ST_IDLE;
            end
            ST_BIAS: begin
               k_ff     <= '0;
               state_ff <= (count_ff == '0) ? ST_FINISH : ST_U_LOAD;
            end
            ST_U_LOAD: begin
               step_ff  <= step_in;
               uaddr_ff <= id_addr(buf_id_q);
               inr_ff   <= 32'(buf_id_q) < 32'(NUM_WEIGHTS);
               state_ff <= ST_U_WR;
            end
            ST_U_WR: begin
               k_ff     <= k_ff + 1'b1;
               state_ff <= last_feature ? ST_FINISH : ST_U_LOAD;
            end
            ST_FINISH: begin
               rsp_valid_ff  <= 1'b1;
               rsp_pred_ff   <= pred_ff;
               rsp_miss_ff   <= miss_ff;
               rsp_err_ff    <= mistakes_ff;
               rsp_ovf_ff    <= ovf_ff;
               rsp_weight_ff <= '0;
               acc_ff        <= '0;
               count_ff      <= '0;
               ovf_ff        <= 1'b0;
               state_ff      <= ST_IDLE;
            end
            ST_READ: begin
               rsp_valid_ff  <= 1'b1;
               rsp_pred_ff   <= 1'b0;
               rsp_miss_ff   <= 1'b0;
               rsp_err_ff    <= mistakes_ff;
               rsp_ovf_ff    <= ovf_ff;
               rsp_weight_ff <= inr_ff ? w_rd_q : '0;
               state_ff      <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.predicted    = rsp_pred_ff;
   assign rsp.mistake      = rsp_miss_ff;
   assign rsp.error_count  = rsp_err_ff;
   assign rsp.overflowed   = rsp_ovf_ff;
   assign rsp.weight_value = rsp_weight_ff;

endmodule

FILE: hw/rtl/sparse_perceptron_trainer_core.sv
`timescale 1ns / 1ps
// channel | direction | transfer when        | payload
// req_bus | in        | valid & ready        | mode, feature_id, feature_value, label_is_one
// rsp_bus | out       | valid & ready        | predicted, mistake, error_count, overflowed,
//         |           |                      | weight_value
// csr     | in        | csr_write_enable     | csr_write_data (learning rate, q0.24)
//
// feature item in the back end: weight read, then multiply, then accumulate
// end of example: predict; on a mistake also a bias update, then a load and a write
// per buffered feature; read weight: memory read; clear error count: at the pop
// after reset the weight memory is swept to zero, with req_bus.ready low
// a 2-entry queue sits between request decode and the sequencer; the sequencer holds
// end and read items until the response register is free

module sparse_perceptron_trainer_core #(
   parameter int NUM_WEIGHTS  = spt_pkg::NumWeightsDefault,
   parameter int MAX_FEATURES = spt_pkg::MaxFeaturesDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   spt_req_if.sink                       req_bus,
   spt_rsp_if.source                     rsp_bus,
   input  logic                          csr_write_enable,
   input  logic [spt_pkg::RateWidth-1:0] csr_write_data
);
   import spt_pkg::*;

   // step size register
   logic [RateWidth-1:0] rate_ff;

   // front to queue
   logic             push;
   op_type           push_op;
   front_status_type front_status;
   logic             queue_full;

   // queue to back
   logic   pop;
   op_type pop_op;
   logic   queue_empty;
   logic   back_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RateReset;
      end else if (csr_write_enable) begin
         rate_ff <= csr_write_data;
      end
   end

   assign front_status.full = queue_full;
   assign front_status.busy = back_busy;

   // decode and classify incoming requests
   spt_front #(
      .NUM_WEIGHTS(NUM_WEIGHTS)
   ) u_front (
      .req    (req_bus),
      .status (front_status),
      .push   (push),
      .op     (push_op)
   );

   // short queue decouples request transfers from the sequencer
   spt_queue #(
      .DEPTH(QueueDepthDefault)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_op),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_op),
      .empty     (queue_empty)
   );

   // weight memory, feature buffer and update sequencer
   spt_back #(
      .NUM_WEIGHTS  (NUM_WEIGHTS),
      .MAX_FEATURES (MAX_FEATURES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .rate     (rate_ff),
      .empty    (queue_empty),
      .pop_data (pop_op),
      .pop      (pop),
      .busy     (back_busy),
      .rsp      (rsp_bus)
   );

endmodule

FILE: hw/rtl/spt_checker.sv
`timescale 1ns / 1ps

module spt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_predicted,
   input logic        rsp_mistake,
   input logic [31:0] rsp_error_count,
   input logic [31:0] rsp_weight_value
);

   // a response stays offered until transferred
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_error_count) && $stable(rsp_weight_value))
      else $error("response payload changed while stalled");

   // nothing is offered right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response offered after reset");

   // end-of-example results carry no weight
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_predicted || rsp_mistake) |-> rsp_weight_value == 32'd0)
      else $error("weight on an end-of-example result");

   // a mistake is always counted
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mistake |-> rsp_error_count != 32'd0)
      else $error("mistake reported with zero error count");

endmodule

bind sparse_perceptron_trainer_core spt_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_predicted    (rsp_bus.predicted),
   .rsp_mistake      (rsp_bus.mistake),
   .rsp_error_count  (rsp_bus.error_count),
   .rsp_weight_value (rsp_bus.weight_value)
);

FILE: test/spt_tb_if.sv
`timescale 1ns / 1ps

// the block's own interfaces (spt_req_if, spt_rsp_if) are used directly;
// this file holds the testbench's shared result type
package spt_tb_types;
   typedef struct {
      logic               predicted;
      logic               mistake;
      logic [31:0]        error_count;
      logic               overflowed;
      logic signed [31:0] weight_value;
   } outcome_type;
endpackage

FILE: test/sparse_perceptron_trainer_core_tb.sv
`timescale 1ns / 1ps

module sparse_perceptron_trainer_core_tb;
   import spt_pkg::*;
   import spt_tb_types::*;

   localparam int NumW = 4096;
   localparam int MaxF = 64;
   localparam longint AccMax = 64'sd36028797018963967;
   localparam longint AccMin = -AccMax - 1;

   // learner state mirrored in the testbench
   class perceptron_board;
      logic signed [31:0] weights [NumW];
      logic [11:0]        feat_ids [MaxF];
      logic signed [15:0] feat_vals [MaxF];
      int                 feat_count;
      longint             dot_sum;
      logic [31:0]        misses;
      bit                 overflow;
      logic [23:0]        rate;
      outcome_type        pending [$];
      int                 fail_count;
      int                 checked;
      int                 mistakes_seen;

      function new();
         foreach (weights[i]) weights[i] = 0;
         feat_count = 0;
         dot_sum = 0;
         misses = 0;
         overflow = 0;
         rate = RateReset;
         fail_count = 0;
         checked = 0;
         mistakes_seen = 0;
      endfunction

      function automatic void bump(int id, longint delta);
         longint w;
         if (id >= NumW) return;
         w = longint'(weights[id]) + delta;
         if (w > 64'sd2147483647) w = 64'sd2147483647;
         if (w < -64'sd2147483648) w = -64'sd2147483648;
         weights[id] = w[31:0];
      endfunction

      // floor((x + 2048) / 4096)
      function automatic longint round_step(longint x);
         return (x + 2048) >>> 12;
      endfunction

      function automatic void note_request(mode_type m, logic [11:0] id,
                                           logic signed [15:0] v, logic lbl);
         outcome_type o;
         longint s;
         bit pred;
         o.predicted = 0;
         o.mistake = 0;
         o.weight_value = 0;
         case (m)
            MODE_FEATURE: begin
               if (feat_count < MaxF) begin
                  s = dot_sum + longint'(weights[id]) * longint'(v);
                  if (s > AccMax) s = AccMax;
                  if (s < AccMin) s = AccMin;
                  dot_sum = s;
                  feat_ids[feat_count] = id;
                  feat_vals[feat_count] = v;
                  feat_count++;
               end else begin
                  overflow = 1;
               end
            end
            MODE_END: begin
               pred = dot_sum > 0;
               o.predicted = pred;
               o.mistake = pred != lbl;
               if (o.mistake) begin
                  if (misses != 32'hFFFF_FFFF) misses++;
                  bump(0, lbl ? longint'(rate) : -longint'(rate));
                  for (int k = 0; k < feat_count; k++) begin
                     s = round_step(longint'(rate) * longint'(feat_vals[k]));
                     bump(feat_ids[k], lbl ? s : -s);
                  end
               end
               o.error_count = misses;
               o.overflowed = overflow;
               pending.push_back(o);
               feat_count = 0;
               dot_sum = 0;
               overflow = 0;
            end
            MODE_READ: begin
               o.error_count = misses;
               o.overflowed = overflow;
               o.weight_value = weights[id];
               pending.push_back(o);
            end
            default: misses = 0;
         endcase
      endfunction

      function automatic void check_result(outcome_type got);
         outcome_type e;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected transfer on rsp_bus", $time);
            fail_count++;
            return;
         end
         e = pending.pop_front();
         if (got.mistake) mistakes_seen++;
         if (got.predicted !== e.predicted || got.mistake !== e.mistake
             || got.error_count !== e.error_count || got.overflowed !== e.overflowed
             || got.weight_value !== e.weight_value) begin
            $display("%0t: mismatch expected p=%0d m=%0d err=%0d ovf=%0d w=%0d",
                     $time, e.predicted, e.mistake, e.error_count, e.overflowed,
                     e.weight_value);
            $display("%0t:          actual   p=%0d m=%0d err=%0d ovf=%0d w=%0d",
                     $time, got.predicted, got.mistake, got.error_count, got.overflowed,
                     got.weight_value);
            fail_count++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write_enable = 0;
   logic [23:0] csr_write_data = '0;

   spt_req_if req_bus ();
   spt_rsp_if rsp_bus ();

   sparse_perceptron_trainer_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   perceptron_board board = new();

   int  send_idle_pct = 0;    // chance in percent that the sender skips a cycle
   int  recv_idle_pct = 0;    // chance in percent that the receiver stalls
   int  hold_cycles = 0;      // long receiver hold-off, counted down in its own process
   int  items_sent = 0;
   int  end_items = 0;
   int  read_items = 0;
   int  overflow_items = 0;

   initial begin
      req_bus.valid = 0;
      req_bus.mode = MODE_FEATURE;
      req_bus.feature_id = '0;
      req_bus.feature_value = '0;
      req_bus.label_is_one = 0;
      rsp_bus.ready = 0;
   end

   // receiver: ready toggled at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_bus.ready <= 0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // result transfer sampled at the rising edge
   always @(posedge clock) begin
      outcome_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.predicted = rsp_bus.predicted;
         got.mistake = rsp_bus.mistake;
         got.error_count = rsp_bus.error_count;
         got.overflowed = rsp_bus.overflowed;
         got.weight_value = rsp_bus.weight_value;
         board.check_result(got);
      end
   end

   // one request transfer; valid stays up across back-to-back items
   task automatic send_request(mode_type m, logic [11:0] id, logic signed [15:0] v,
                               logic lbl);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 0;
         @(negedge clock);
      end
      req_bus.valid <= 1;
      req_bus.mode <= m;
      req_bus.feature_id <= id;
      req_bus.feature_value <= v;
      req_bus.label_is_one <= lbl;
      do @(posedge clock); while (!req_bus.ready);
      board.note_request(m, id, v, lbl);
      items_sent++;
      if (m == MODE_END) end_items++;
      if (m == MODE_READ) read_items++;
      @(negedge clock);
   endtask

   task automatic go_idle();
      req_bus.valid <= 0;
      @(negedge clock);
   endtask

   // wait for all results, then let the sequencer settle before a rate write
   task automatic drain();
      go_idle();
      while (board.pending.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic write_rate(logic [23:0] r);
      csr_write_enable <= 1;
      csr_write_data <= r;
      @(negedge clock);
      csr_write_enable <= 0;
      board.rate = r;
   endtask

   // features drawn mostly from a small id pool so weights get revisited
   function automatic logic [11:0] pick_id();
      int r = $urandom_range(99);
      if (r < 70) return 12'($urandom_range(15));
      if (r < 85) return 12'($urandom_range(4095));
      return 12'(4095 - $urandom_range(3));
   endfunction

   function automatic logic [15:0] pick_value();
      int r = $urandom_range(9);
      if (r == 0) return 16'h7FFF;
      if (r == 1) return 16'h8000;
      return 16'($urandom());
   endfunction

   // one example: a few features then the labeled end, sometimes noise in between
   task automatic random_example(int max_len);
      int n = $urandom_range(max_len);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(19) == 0)
            send_request(MODE_READ, pick_id(), 16'($urandom()), 1'($urandom()));
         else
            send_request(MODE_FEATURE, pick_id(), pick_value(), 1'($urandom()));
      end
      if ($urandom_range(29) == 0)
         send_request(MODE_CLEAR, 12'($urandom()), 16'($urandom()), 1'($urandom()));
      send_request(MODE_END, 12'($urandom()), 16'($urandom()), 1'($urandom()));
   endtask

   task automatic random_phase(int count);
      int start = items_sent;
      while (items_sent - start < count) random_example(8);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: id and value extremes, every mode
      send_request(MODE_FEATURE, 12'd0, 16'sh7FFF, 0);
      send_request(MODE_FEATURE, 12'd4095, 16'sh8000, 0);
      send_request(MODE_END, 12'd0, 16'sd0, 1);          // mistake, label one
      send_request(MODE_READ, 12'd0, 16'sd0, 0);
      send_request(MODE_READ, 12'd4095, 16'sd0, 0);
      send_request(MODE_FEATURE, 12'd0, 16'sh7FFF, 0);
      send_request(MODE_END, 12'd0, 16'sd0, 0);          // positive sum, label zero
      send_request(MODE_END, 12'd0, 16'sd0, 0);          // empty example, no mistake
      send_request(MODE_CLEAR, 12'hFFF, 16'shFFFF, 1);
      send_request(MODE_READ, 12'hAAA, 16'sh5555, 1);
      send_request(MODE_READ, 12'h555, 16'shAAAA, 0);
      drain();

      // buffer overflow: more features than the buffer holds
      write_rate(24'hFFFFFF);
      for (int k = 0; k < MaxF + 3; k++) begin
         send_request(MODE_FEATURE, 12'(k % 5), -16'sd4096, 0);
         if (k >= MaxF) overflow_items++;
      end
      send_request(MODE_READ, 12'd1, 16'sd0, 0);         // overflow flag seen in a read
      send_request(MODE_END, 12'd0, 16'sd0, 1);
      drain();

      write_rate(24'd0);
      send_idle_pct = 7;
      recv_idle_pct = 69;
      random_phase(120);
      drain();

      write_rate(24'hFFFFFF);
      send_idle_pct = 69;
      recv_idle_pct = 7;
      random_phase(120);
      drain();

      // receiver holds off while the sender keeps offering reads and ends
      write_rate(RateReset);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 400;
      for (int k = 0; k < 12; k++)
         send_request(MODE_READ, 12'($urandom_range(15)), 16'sd0, 0);
      random_phase(40);
      drain();

      write_rate(24'($urandom()));
      random_phase(80);
      drain();

      $display("covered %0d requests: %0d example ends, %0d weight reads, %0d ignored",
               items_sent, end_items, read_items, overflow_items);
      $display("%0d results checked, %0d with a training mistake",
               board.checked, board.mistakes_seen);
      if (board.fail_count == 0 && board.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout with %0d results outstanding", board.pending.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
